@@ hdl/csem_pkg.sv @@
// ----------------------------------------------------------------------------
// csem_pkg: shared types and constants
// Widths, operation and status codes, sequencer states and result record
// for the counting semaphore table.
// ----------------------------------------------------------------------------
package csem_pkg;

  localparam int SLOTS    = 16;
  localparam int CNT_W    = 32;
  localparam int ID_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NUM_W    = $clog2(SLOTS + 1);
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;
  localparam int IN_W     = OP_W + ID_W + CNT_W;
  localparam int IN_BYTES = (IN_W + 7) / 8;
  localparam int OUT_W    = STAT_W + ID_W + 1 + CNT_W + NUM_W;
  localparam int OUT_BYTES = (OUT_W + 7) / 8;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_SIGNAL = 2'd2,
    OP_WAIT   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ID    = 2'd1,
    ST_NO_FREE   = 2'd2,
    ST_MUST_WAIT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ALU_PASS,
    ALU_INC,
    ALU_DEC
  } alu_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [NUM_W-1:0] active;
    logic [CNT_W-1:0] cnt;
    logic             wake;
    logic [ID_W-1:0]  granted;
    status_t          status;
  } res_t;

endpackage

@@ hdl/counting_semaphore_table.sv @@
// ----------------------------------------------------------------------------
// counting_semaphore_table: table of counting semaphores
// Allocate with round-robin search, free, signal (V) and wait (P) requests
// served one at a time by a small sequencer around a shared count unit.
// ----------------------------------------------------------------------------
// free, signal, wait: count ram read, update, result load
// invalid id: result load without a count ram read
// allocate: a search that probes one busy bit per cycle, then result load
// result register frees the request side; a waiting result stalls the next load
// synchronous active-low reset clears busy marks, counts, pointer and total;
// active_slots resets to 16
module counting_semaphore_table
  import csem_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_BYTES*8-1:0]  in_tdata,   // op, sem_id, initial_value
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_BYTES*8-1:0] out_tdata,  // status, granted_id, wake_waiters,
                                             // count_after, active_count
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [NUM_W-1:0]       cfg_data    // active_slots
);

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [CNT_W-1:0]  init_r, init_nxt;
  logic [NUM_W-1:0]  n_r, n_nxt;
  logic [ID_W-1:0]   idx_r, idx_nxt;
  logic [NUM_W-1:0]  steps_r, steps_nxt;
  logic [SLOTS-1:0]  busy_r, busy_nxt;
  logic [ID_W-1:0]   next_free_r, next_free_nxt;
  logic [NUM_W-1:0]  total_r, total_nxt;
  logic [NUM_W-1:0]  active_slots_r;
  res_t              res_r, res_nxt;
  logic              out_vld_r;
  res_t              out_r;

  logic [NUM_W-1:0]  n_sat;
  logic [NUM_W-1:0]  idx_inc;
  logic [ID_W-1:0]   idx_wrap;
  logic              in_xfer;
  logic              out_free;

  logic              wr_en;
  logic [ID_W-1:0]   wr_addr;
  logic [CNT_W-1:0]  wr_data;
  logic              rd_en;
  logic [CNT_W-1:0]  rd_data;
  alu_op_t           alu_mode;
  logic [CNT_W-1:0]  alu_y;
  logic              alu_zero;

  op_t               in_op;
  logic [ID_W-1:0]   in_id;
  logic [CNT_W-1:0]  in_init;

  assign in_op   = op_t'(in_tdata[OP_W-1:0]);
  assign in_id   = in_tdata[OP_W +: ID_W];
  assign in_init = in_tdata[OP_W+ID_W +: CNT_W];

  assign cfg_ready = rst_n;
  assign in_tready = rst_n && (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;

  always_comb begin
    if (active_slots_r == '0) begin
      n_sat = NUM_W'(1);
    end else if (active_slots_r > NUM_W'(SLOTS)) begin
      n_sat = NUM_W'(SLOTS);
    end else begin
      n_sat = active_slots_r;
    end
  end

  assign idx_inc  = {1'b0, idx_r} + NUM_W'(1);
  assign idx_wrap = (idx_inc < n_r) ? idx_inc[ID_W-1:0] : '0;

  csem_cnt_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (in_id),
    .rd_data (rd_data)
  );

  csem_alu u_alu (
    .mode   (alu_mode),
    .a      (rd_data),
    .y      (alu_y),
    .a_zero (alu_zero)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      busy_r         <= '0;
      next_free_r    <= '0;
      total_r        <= '0;
      active_slots_r <= NUM_W'(SLOTS);
      out_vld_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      next_free_r <= next_free_nxt;
      total_r     <= total_nxt;
      if (cfg_valid && cfg_ready) begin
        active_slots_r <= cfg_data;
      end
      if (state_r == S_DONE && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    id_r    <= id_nxt;
    init_r  <= init_nxt;
    n_r     <= n_nxt;
    idx_r   <= idx_nxt;
    steps_r <= steps_nxt;
    res_r   <= res_nxt;
    if (state_r == S_DONE && out_free) begin
      out_r <= res_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    init_nxt      = init_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    steps_nxt     = steps_r;
    busy_nxt      = busy_r;
    next_free_nxt = next_free_r;
    total_nxt     = total_r;
    res_nxt       = res_r;
    wr_en         = 1'b0;
    wr_addr       = id_r;
    wr_data       = alu_y;
    rd_en         = 1'b0;
    alu_mode      = ALU_PASS;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt    = in_op;
          id_nxt    = in_id;
          init_nxt  = in_init;
          n_nxt     = n_sat;
          steps_nxt = '0;
          idx_nxt   = ({1'b0, next_free_r} < n_sat) ? next_free_r : '0;
          res_nxt   = '{active: total_r, cnt: '0, wake: 1'b0, granted: '0,
                        status: ST_OK};
          if (in_op == OP_ALLOC) begin
            state_nxt = S_SCAN;
          end else if ({1'b0, in_id} >= n_sat) begin
            res_nxt.status = ST_BAD_ID;
            state_nxt      = S_DONE;
          end else begin
            rd_en     = 1'b1;
            state_nxt = S_EXEC;
          end
        end
      end
      S_SCAN: begin
        if (!busy_r[idx_r]) begin
          wr_en             = 1'b1;
          wr_addr           = idx_r;
          wr_data           = init_r;
          busy_nxt[idx_r]   = 1'b1;
          next_free_nxt     = idx_wrap;
          total_nxt         = total_r + NUM_W'(1);
          res_nxt.granted   = idx_r;
          res_nxt.cnt       = init_r;
          res_nxt.active    = total_r + NUM_W'(1);
          state_nxt         = S_DONE;
        end else if (steps_r + NUM_W'(1) >= n_r) begin
          res_nxt.status = ST_NO_FREE;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt   = idx_wrap;
          steps_nxt = steps_r + NUM_W'(1);
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (op_r)
          OP_FREE: begin
            alu_mode      = ALU_PASS;
            next_free_nxt = id_r;
            res_nxt.cnt   = rd_data;
            if (busy_r[id_r]) begin
              busy_nxt[id_r] = 1'b0;
              total_nxt      = total_r - NUM_W'(1);
              res_nxt.active = total_r - NUM_W'(1);
            end
          end
          OP_SIGNAL: begin
            alu_mode     = ALU_INC;
            wr_en        = 1'b1;
            res_nxt.wake = alu_zero;
            res_nxt.cnt  = alu_y;
          end
          OP_WAIT: begin
            alu_mode = ALU_DEC;
            if (alu_zero) begin
              res_nxt.status = ST_MUST_WAIT;
            end else begin
              wr_en       = 1'b1;
              res_nxt.cnt = alu_y;
            end
          end
          default: begin
            alu_mode = ALU_PASS;
          end
        endcase
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_BYTES*8-OUT_W){1'b0}}, out_r.active, out_r.cnt,
                       out_r.wake, out_r.granted, out_r.status};

  a_total_matches_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(busy_r) == 32'(total_r))
    else $error("allocated total differs from busy marks");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r != S_IDLE)
    else $error("request transfer did not start the sequencer");

  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> steps_r < n_r)
    else $error("allocate search ran past the slots in use");

endmodule

@@ hdl/csem_cnt_ram.sv @@
// ----------------------------------------------------------------------------
// csem_cnt_ram: semaphore count store
// One write port, one registered read port; per-entry valid bits make
// entries read as zero until written after reset.
// ----------------------------------------------------------------------------
module csem_cnt_ram
  import csem_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [ID_W-1:0]  wr_addr,
  input  logic [CNT_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [ID_W-1:0]  rd_addr,
  output logic [CNT_W-1:0] rd_data
);

  logic [CNT_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0] vld_r;
  logic [CNT_W-1:0] rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

@@ hdl/csem_alu.sv @@
// ----------------------------------------------------------------------------
// csem_alu: shared count unit
// Increments, decrements or passes a count and flags a zero operand.
// ----------------------------------------------------------------------------
module csem_alu
  import csem_pkg::*;
(
  input  alu_op_t          mode,
  input  logic [CNT_W-1:0] a,
  output logic [CNT_W-1:0] y,
  output logic             a_zero
);

  always_comb begin
    unique case (mode)
      ALU_INC: y = a + CNT_W'(1);
      ALU_DEC: y = a - CNT_W'(1);
      default: y = a;
    endcase
  end

  assign a_zero = (a == '0);

endmodule
